FILE: rtl/core/wildcard_byte_pattern_scanner_unit_defines.svh
// assertion macros for the wildcard byte pattern scanner
// used by the top level; no other dependencies
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define WBPS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wbps assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define WBPS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wbps assertion failed");

`else

`define WBPS_ASSERT_IMP(name, ante, cons)
`define WBPS_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: rtl/core/wbps_pkg.sv
// shared types and constants of the wildcard byte pattern scanner
// no dependencies
package wbps_pkg;

	// item operations
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SCAN  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [1:0] REG_MAX_MISMATCHES = 2'd1;
	localparam logic [1:0] REG_MATCH_LIMIT    = 2'd2;

	// register reset values
	localparam logic [6:0] LENGTH_RESET = 7'd1;
	localparam logic [6:0] MAX_MIS_RESET = 7'd0;
	localparam logic [7:0] LIMIT_RESET  = 8'd20;

	// width of the reported start position
	localparam int POS_OUT_W = 32;

	// broadcast control to every cell of the chain
	typedef struct packed {
		logic       shift;
		logic       rotate;
		logic       load;
		logic       capture;
		logic [7:0] load_byte;
		logic       load_wild;
	} cell_ctrl_t;

	// sideband that travels with a scan or new-scan item down the pipeline
	typedef struct packed {
		logic                 clear;
		logic                 check;
		logic                 last;
		logic [POS_OUT_W-1:0] start;
	} side_t;

endpackage

FILE: rtl/core/wbps_cell.sv
// one cell of the scanner chain: a window byte, a pattern element and its mismatch flag
// depends on wbps_pkg
module wbps_cell import wbps_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       load_sel,
	input  logic       active,
	input  logic [7:0] data_in,
	input  logic [7:0] pat_in,
	input  logic       wild_in,
	output logic [7:0] data_q,
	output logic [7:0] pat_q,
	output logic       wild_q,
	output logic       miss_q
);

	// window byte moves one cell up on every scan byte
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= data_in;
		end
	end

	// pattern element rotates around the ring or takes a load
	always_ff @(posedge clk) begin
		if (ctrl.rotate) begin
			pat_q  <= pat_in;
			wild_q <= wild_in;
		end else if (ctrl.load && load_sel) begin
			pat_q  <= ctrl.load_byte;
			wild_q <= ctrl.load_wild;
		end
	end

	// per-cell compare, registered
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			miss_q <= active && !wild_q && (data_q != pat_q);
		end
	end

endmodule

FILE: rtl/core/wbps_miss_sum.sv
// two-stage registered count of the mismatch flags of all cells
// depends on wbps_pkg
module wbps_miss_sum import wbps_pkg::*; #(
	parameter int CELLS = 64
) (
	input  logic                         clk,
	input  logic [CELLS-1:0]             miss,
	input  logic                         en_s2,
	input  logic                         en_s3,
	output logic [$clog2(CELLS+1)-1:0]   total_s3
);

	localparam int CW = $clog2(CELLS + 1);
	localparam int NG = (CELLS + 7) / 8;

	logic [NG*8-1:0] miss_pad;
	logic [3:0]      grp_d  [NG];
	logic [3:0]      grp_s2 [NG];
	logic [CW-1:0]   total_d;

	assign miss_pad = (NG*8)'(miss);

	// popcount of each group of eight cells
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int b = 0; b < 8; b++) begin
				grp_d[g] = grp_d[g] + 4'(miss_pad[g*8 + b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			grp_s2 <= grp_d;
		end
	end

	// sum of the group counts
	always_comb begin
		total_d = '0;
		for (int g = 0; g < NG; g++) begin
			total_d = total_d + CW'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			total_s3 <= total_d;
		end
	end

endmodule

FILE: rtl/core/wildcard_byte_pattern_scanner_unit.sv
// top level of the wildcard byte pattern scanner: control, cell chain and result register
// depends on wbps_pkg, wbps_cell, wbps_miss_sum and the assertion macro header
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: op 0 loads a
//   pattern element, op 1 scans one data byte, op 2 starts a new scan. Output channel
//   (out_valid / out_stall) carries at most one result per scan byte: a match, a done
//   marker for a byte flagged last_byte, or both in one result.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes pattern_length,
//   max_mismatches and match_limit; cfg_ready is always high.
//   Throughput: one item per cycle while in_stall is low. Each scan byte shifts the
//   window one cell up the chain; every cell compares its byte against its own
//   pattern element in parallel. A result passes the window shift, cell compare,
//   group count, total count and decision registers before it shows on out_valid.
//   After a write of pattern_length the pattern ring rotates one cell per cycle to
//   line up with the new length; in_stall is high while it rotates.
//   Reset clears the registers to their reset values and empties the pipeline;
//   pattern contents are not cleared and no clearing pass is run.
//   When the receiver stalls, the result register holds; the pipeline keeps taking
//   items until its stages are full, then in_stall rises.
`include "wildcard_byte_pattern_scanner_unit_defines.svh"

module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; #(
	parameter int PATTERN_MAX   = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [5:0]  element_index,
	input  logic [7:0]  byte_value,
	input  logic        wildcard_req,
	input  logic        last_byte,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [31:0] match_position,
	output logic [6:0]  mismatches,
	output logic [7:0]  match_number,
	output logic        scan_done
);

	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CW = $clog2(PATTERN_MAX + 1);

	// configuration registers
	logic [6:0] length_q;
	logic [6:0] max_mis_q;
	logic [7:0] limit_q;

	// scan state
	logic [IW-1:0]            off_q;
	logic [LW-1:0]            fill_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [7:0]               match_count_q;

	// pipeline control
	logic  valid_s0, valid_s1, valid_s2, valid_s3, out_valid_q;
	side_t side_s0, side_s1, side_s2, side_s3;
	logic  adv0, adv1, adv2, adv3;

	// decode and derived values
	logic [LW-1:0]            len_eff;
	logic [IW-1:0]            off_target;
	logic                     rotating;
	logic                     in_acc, scan_acc, clear_acc, load_acc;
	logic                     idx_ok;
	logic [IW-1:0]            idx_n;
	logic [IW:0]              wdiff;
	logic [IW-1:0]            wpos;
	logic [LW-1:0]            fill_inc;
	logic                     check_d;
	logic [POSITION_BITS-1:0] start_full;
	side_t                    side_d;

	// chain wiring
	cell_ctrl_t             ctrl;
	logic [7:0]             data_w [PATTERN_MAX];
	logic [7:0]             pat_w  [PATTERN_MAX];
	logic                   wild_w [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] miss_vec;
	logic [CW-1:0]          total_s3;

	// decision
	logic found3, emit3, out_free;

	assign cfg_ready = 1'b1;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= LENGTH_RESET;
			max_mis_q <= MAX_MIS_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: length_q  <= cfg_data[6:0];
				REG_MAX_MISMATCHES: max_mis_q <= cfg_data[6:0];
				REG_MATCH_LIMIT:    limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective length and ring alignment target
	always_comb begin
		if (int'(length_q) > PATTERN_MAX) begin
			len_eff = LW'(PATTERN_MAX);
		end else begin
			len_eff = LW'(length_q);
		end
		if (len_eff == '0) begin
			off_target = IW'(PATTERN_MAX - 1);
		end else begin
			off_target = IW'(len_eff - LW'(1));
		end
	end

	assign rotating = (off_q != off_target);

	// ring offset steps up once per cycle until it lines up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (rotating) begin
			if (off_q == IW'(PATTERN_MAX - 1)) begin
				off_q <= '0;
			end else begin
				off_q <= off_q + IW'(1);
			end
		end
	end

	// input handshake and item decode
	assign in_stall  = rotating || (valid_s0 && !adv0);
	assign in_acc    = in_valid && !in_stall;
	assign scan_acc  = in_acc && (op == OP_SCAN);
	assign clear_acc = in_acc && (op == OP_CLEAR);
	assign load_acc  = in_acc && (op == OP_LOAD);

	// ring position of a loaded element
	always_comb begin
		idx_ok = int'(element_index) < PATTERN_MAX;
		idx_n  = IW'(element_index);
		wdiff  = {1'b0, off_q} - {1'b0, idx_n};
		if (wdiff[IW]) begin
			wpos = IW'(wdiff + (IW+1)'(PATTERN_MAX));
		end else begin
			wpos = IW'(wdiff);
		end
	end

	// window fill, match check and start offset for a scan byte
	always_comb begin
		if (fill_q == LW'(PATTERN_MAX)) begin
			fill_inc = fill_q;
		end else begin
			fill_inc = fill_q + LW'(1);
		end
		check_d      = (len_eff != '0) && (fill_inc >= len_eff);
		start_full   = pos_q - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
		side_d.clear = clear_acc;
		side_d.check = scan_acc && check_d;
		side_d.last  = scan_acc && last_byte;
		side_d.start = POS_OUT_W'(start_full);
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (clear_acc) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (scan_acc) begin
			fill_q <= fill_inc;
			pos_q  <= pos_q + POSITION_BITS'(1);
		end
	end

	// stage advance, bubbles collapse
	assign out_free = !out_valid_q || !out_stall;
	assign adv3 = valid_s3 && (emit3 ? out_free : 1'b1);
	assign adv2 = valid_s2 && (!valid_s3 || adv3);
	assign adv1 = valid_s1 && (!valid_s2 || adv2);
	assign adv0 = valid_s0 && (!valid_s1 || adv1);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (scan_acc || clear_acc) begin
				valid_s0 <= 1'b1;
			end else if (adv0) begin
				valid_s0 <= 1'b0;
			end
			if (adv0) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				valid_s3 <= 1'b1;
			end else if (adv3) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// sideband registers
	always_ff @(posedge clk) begin
		if (scan_acc || clear_acc) begin
			side_s0 <= side_d;
		end
		if (adv0) begin
			side_s1 <= side_s0;
		end
		if (adv1) begin
			side_s2 <= side_s1;
		end
		if (adv2) begin
			side_s3 <= side_s2;
		end
	end

	// cell chain control
	always_comb begin
		ctrl.shift     = scan_acc;
		ctrl.rotate    = rotating;
		ctrl.load      = load_acc && idx_ok;
		ctrl.capture   = adv0;
		ctrl.load_byte = byte_value;
		ctrl.load_wild = wildcard_req;
	end

	// row of cells: window bytes move up, pattern ring wraps from the top cell to cell 0
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		localparam int PREV = (k == 0) ? PATTERN_MAX - 1 : k - 1;
		logic [7:0] data_in;
		logic       sel;
		logic       active;

		assign data_in = (k == 0) ? byte_value : data_w[PREV];
		assign sel     = (wpos == IW'(k));
		assign active  = int'(len_eff) > k;

		wbps_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.load_sel (sel),
			.active   (active),
			.data_in  (data_in),
			.pat_in   (pat_w[PREV]),
			.wild_in  (wild_w[PREV]),
			.data_q   (data_w[k]),
			.pat_q    (pat_w[k]),
			.wild_q   (wild_w[k]),
			.miss_q   (miss_vec[k])
		);
	end

	// mismatch count over all cells
	wbps_miss_sum #(
		.CELLS (PATTERN_MAX)
	) u_sum (
		.clk      (clk),
		.miss     (miss_vec),
		.en_s2    (adv1),
		.en_s3    (adv2),
		.total_s3 (total_s3)
	);

	// match decision
	assign found3 = !side_s3.clear && side_s3.check
		&& (int'(total_s3) <= int'(max_mis_q))
		&& (match_count_q < limit_q);
	assign emit3 = !side_s3.clear && (found3 || side_s3.last);

	// running match count, cleared in order by a new-scan item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q <= '0;
		end else if (adv3) begin
			if (side_s3.clear) begin
				match_count_q <= '0;
			end else if (found3) begin
				match_count_q <= match_count_q + 8'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv3 && emit3) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && emit3) begin
			match_found    <= found3;
			match_position <= found3 ? side_s3.start : '0;
			mismatches     <= found3 ? 7'(total_s3) : '0;
			match_number   <= found3 ? match_count_q + 8'd1 : match_count_q;
			scan_done      <= side_s3.last;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`WBPS_ASSERT_NXT(a_s0_hold, valid_s0 && !adv0, valid_s0 && $stable(side_s0))
	`WBPS_ASSERT_IMP(a_match_number, out_valid && match_found, match_number != 8'd0)
	`WBPS_ASSERT_NXT(a_clear_count, valid_s3 && side_s3.clear && adv3, match_count_q == 8'd0)
	`WBPS_ASSERT_NXT(a_scan_enters, scan_acc, valid_s0 && !side_s0.clear)

endmodule
